@@ rtl/core/logistic_mixed_gradient_engine_unit_macros.svh @@
// Assertion macros for the gradient engine
`ifndef LOGISTIC_MIXED_GRADIENT_ENGINE_UNIT_MACROS_SVH
`define LOGISTIC_MIXED_GRADIENT_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LMG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LMG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/lmg_pkg.sv @@
package lmg_pkg;
  localparam int NCOEF = 17;
  localparam int NCAT = 4;
  localparam int NLEV = 4;
  localparam int NCONT = 4;
  localparam int IN_W = 176;
  localparam int OUT_W = 72;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_START = 2'd1,
    OP_OBS = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_LEV0 = 3'd0,
    REG_LEV1 = 3'd1,
    REG_LEV2 = 3'd2,
    REG_LEV3 = 3'd3,
    REG_CONT = 3'd4,
    REG_L1 = 3'd5,
    REG_L2 = 3'd6
  } reg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  idx;
    logic [31:0] val;
    logic [3:0][1:0] cat;
    logic [3:0][31:0] cont;
    logic        label;
  } item_t;

  typedef struct packed {
    logic [15:0] prob;
    logic [4:0]  gidx;
    logic [47:0] gval;
    logic        last;
    logic        lerr;
  } res_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sh00007FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
    if (v < -64'sh0000800000000000) return 48'sh800000000000;
    return v[47:0];
  endfunction
endpackage

@@ rtl/core/logistic_mixed_gradient_engine_unit.sv @@
// Logistic-regression gradient engine. A small input queue decouples acceptance
// from a sequential back end. A start multiplies and writes per coefficient, an
// observation multiplies and adds each used continuous input, and a read gives one
// gradient entry per cycle unless the output stalls. Configure only while idle.
`include "logistic_mixed_gradient_engine_unit_macros.svh"
module logistic_mixed_gradient_engine_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // coef_index, coef_value, cat_a..cat_d, cont_a..cont_d, label
  input  logic [175:0] in_tdata,
  // operation
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // probability, grad_index, grad_value, level_error
  output logic [71:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import lmg_pkg::*;
  logic [3:0][2:0] lev_r;
  logic [2:0] cont_r;
  logic [31:0] l1_r, l2_r;
  logic q_valid, q_pop, busy;
  item_t q_item;
  res_t res;

  assign cfg_pready = 1'b1;
  wire wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lev_r <= {4{3'd3}}; cont_r <= '0; l1_r <= '0; l2_r <= '0;
    end else if (wr) begin
      case (cfg_paddr[4:2])
        REG_LEV0: lev_r[0] <= cfg_pwdata[2:0];
        REG_LEV1: lev_r[1] <= cfg_pwdata[2:0];
        REG_LEV2: lev_r[2] <= cfg_pwdata[2:0];
        REG_LEV3: lev_r[3] <= cfg_pwdata[2:0];
        REG_CONT: cont_r <= cfg_pwdata[2:0];
        REG_L1: l1_r <= cfg_pwdata;
        REG_L2: l2_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[4:2])
      REG_LEV0: cfg_prdata = {29'b0, lev_r[0]};
      REG_LEV1: cfg_prdata = {29'b0, lev_r[1]};
      REG_LEV2: cfg_prdata = {29'b0, lev_r[2]};
      REG_LEV3: cfg_prdata = {29'b0, lev_r[3]};
      REG_CONT: cfg_prdata = {29'b0, cont_r};
      REG_L1: cfg_prdata = l1_r;
      REG_L2: cfg_prdata = l2_r;
      default: cfg_prdata = '0;
    endcase
  end

  lmg_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_valid, .q_pop, .q_item);
  lmg_back u_back (.clk, .rst_n, .q_valid, .q_pop, .q_item, .lev(lev_r),
    .cont_used(cont_r), .lam1(l1_r), .lam2(l2_r), .out_tvalid, .out_tready,
    .out_res(res), .busy);

  assign out_tdata = {2'b0, res.lerr, res.gval, res.gidx, res.prob};
  assign out_tlast = res.last;

  `LMG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `LMG_ASSERT_IMPL(a_pop_valid, clk, rst_n, q_pop, q_valid)
  `LMG_ASSERT_IMPL(a_busy_out, clk, rst_n, q_valid, busy)
endmodule

@@ rtl/core/lmg_front.sv @@
module lmg_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [175:0]  in_tdata,
  input  logic [1:0]    in_tuser,
  output logic          q_valid,
  input  logic          q_pop,
  output lmg_pkg::item_t q_item
);
  import lmg_pkg::*;
  item_t mem_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  item_t it;
  assign it.op = in_tuser;
  assign it.idx = in_tdata[4:0];
  assign it.val = in_tdata[36:5];
  assign it.cat = {in_tdata[44:43], in_tdata[42:41], in_tdata[40:39], in_tdata[38:37]};
  assign it.cont = {in_tdata[172:141], in_tdata[140:109], in_tdata[108:77], in_tdata[76:45]};
  assign it.label = in_tdata[173];
  assign in_tready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = mem_r[rp_r];
  wire push = in_tvalid && in_tready;
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= it;
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

@@ rtl/core/lmg_back.sv @@
module lmg_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  lmg_pkg::item_t q_item,
  input  logic [3:0][2:0] lev,
  input  logic [2:0]     cont_used,
  input  logic [31:0]    lam1,
  input  logic [31:0]    lam2,
  output logic           out_tvalid,
  input  logic           out_tready,
  output lmg_pkg::res_t  out_res,
  output logic           busy
);
  import lmg_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_START, S_ETA, S_ETA2, S_SIG, S_UPD, S_READ} st_t;
  st_t st_r;
  logic signed [31:0] coef_r [NCOEF];
  logic signed [47:0] grad_r [NCOEF];
  item_t cur_r;
  logic [4:0] i_r;
  logic [2:0] k_r;
  logic signed [63:0] eta_r, prod_r;
  logic [15:0] prob_r;
  logic lerr_r;
  logic [3:0] use_r;
  logic [3:0][4:0] slot_r;
  logic [4:0] base_r;
  logic ov_r;
  res_t res_r;

  logic [3:0][2:0] nl;
  logic [2:0] nc;
  logic [4:0] npar;
  always_comb begin
    npar = 5'd1;
    for (int k = 0; k < NCAT; k++) begin
      nl[k] = (lev[k] == 3'd0) ? 3'd1 : (lev[k] > 3'd4) ? 3'd4 : lev[k];
      npar = npar + {2'b0, nl[k]} - 5'd1;
    end
    nc = (cont_used > 3'd4) ? 3'd4 : cont_used;
    npar = npar + {2'b0, nc};
  end

  // categorical decode
  logic [3:0] use_c;
  logic [3:0][4:0] slot_c;
  logic lerr_c;
  logic [4:0] base_c;
  always_comb begin
    base_c = 5'd1; lerr_c = 1'b0;
    for (int k = 0; k < NCAT; k++) begin
      use_c[k] = 1'b0;
      slot_c[k] = base_c + {3'b0, q_item.cat[k]} - 5'd1;
      if ({1'b0, q_item.cat[k]} >= nl[k]) lerr_c = 1'b1;
      else if (q_item.cat[k] != 2'd0) use_c[k] = 1'b1;
      base_c = base_c + {2'b0, nl[k]} - 5'd1;
    end
  end

  // start term
  logic signed [31:0] sc;
  logic signed [63:0] sterm;
  assign sc = coef_r[i_r];
  always_comb begin
    sterm = prod_r >>> 16;
  end

  logic signed [63:0] eta_cat;
  always_comb begin
    eta_cat = 64'(coef_r[0]);
    for (int k = 0; k < NCAT; k++)
      if (use_r[k]) eta_cat = eta_cat + 64'(coef_r[slot_r[k]]);
  end

  // sigmoid
  logic [63:0] a;
  logic [24:0] y;
  logic [24:0] p;
  logic [16:0] pr;
  always_comb begin
    a = eta_r[63] ? 64'(-eta_r) : 64'(eta_r);
    if (a >= 64'd83886080) y = 25'd16777216;
    else if (a >= 64'd39845888) y = 25'(a >> 5) + 25'd14155776;
    else if (a >= 64'd16777216) y = 25'(a >> 3) + 25'd10485760;
    else y = 25'(a >> 2) + 25'd8388608;
    p = eta_r[63] ? 25'd16777216 - y : y;
    pr = 17'((p + 25'd128) >> 8);
  end

  logic signed [17:0] err;
  assign err = $signed({2'b0, prob_r}) - (cur_r.label ? 18'sd65536 : 18'sd0);
  logic signed [31:0] xk;
  assign xk = cur_r.cont[k_r[1:0]];

  wire out_free = !out_tvalid || out_tready;
  wire emit = out_free && ((st_r == S_READ) ||
                           (st_r == S_UPD && i_r > 5'd4 && k_r >= nc));
  assign q_pop = (st_r == S_IDLE) && q_valid && out_free;
  assign busy = (st_r != S_IDLE) || q_valid;
  assign out_res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_tvalid <= 1'b0;
      for (int j = 0; j < NCOEF; j++) grad_r[j] <= '0;
    end else begin
      if (out_tvalid && out_tready && !emit) out_tvalid <= 1'b0;
      case (st_r)
        S_IDLE: if (q_pop) begin
          cur_r <= q_item; use_r <= use_c; slot_r <= slot_c;
          lerr_r <= lerr_c; base_r <= base_c; i_r <= '0; k_r <= '0; ov_r <= 1'b0;
          case (q_item.op)
            OP_LOAD: if (q_item.idx < 5'd17) coef_r[q_item.idx] <= q_item.val;
            OP_START: st_r <= S_START;
            OP_OBS: st_r <= S_ETA;
            OP_READ: st_r <= S_READ;
            default: ;
          endcase
        end
        S_START: begin
          // two phases per entry: multiply then write
          if (!ov_r) begin
            prod_r <= 64'(sc) * $signed({32'b0, lam2});
            ov_r <= 1'b1;
          end else begin
            ov_r <= 1'b0;
            if (i_r == 5'd0 || i_r >= npar) grad_r[i_r] <= '0;
            else grad_r[i_r] <= sat48(sterm + ((sc > 0) ? $signed({24'b0, lam1, 8'b0})
              : (sc < 0) ? -$signed({24'b0, lam1, 8'b0}) : 64'sd0));
            if (i_r == 5'(NCOEF - 1)) st_r <= S_IDLE;
            i_r <= i_r + 5'd1;
          end
        end
        S_ETA: begin
          eta_r <= eta_cat; k_r <= '0; ov_r <= 1'b0; st_r <= S_ETA2;
        end
        S_ETA2: begin
          if (k_r >= nc) st_r <= S_SIG;
          else if (!ov_r) begin
            prod_r <= 64'(xk) * 64'(coef_r[base_r + {2'b0, k_r}]);
            ov_r <= 1'b1;
          end else begin
            eta_r <= eta_r + (prod_r >>> 16);
            ov_r <= 1'b0; k_r <= k_r + 3'd1;
          end
        end
        S_SIG: begin
          prob_r <= pr[16] ? 16'hFFFF : pr[15:0];
          st_r <= S_UPD; k_r <= '0; i_r <= '0;
        end
        S_UPD: begin
          // intercept, dummies, then continuous entries one per step
          if (i_r == 5'd0) begin
            grad_r[0] <= sat48(64'(grad_r[0]) + 64'(err) * 64'sd256);
            i_r <= 5'd1;
          end else if (i_r <= 5'd4) begin
            if (use_r[i_r[1:0] - 2'd1])
              grad_r[slot_r[i_r[1:0] - 2'd1]] <= sat48(64'(grad_r[slot_r[i_r[1:0] - 2'd1]])
                + 64'(err) * 64'sd256);
            i_r <= i_r + 5'd1;
          end else if (k_r < nc) begin
            grad_r[base_r + {2'b0, k_r}] <= sat48(64'(grad_r[base_r + {2'b0, k_r}])
              + ((64'(xk) * 64'(err)) >>> 8));
            k_r <= k_r + 3'd1;
          end else if (out_free) begin
            res_r <= '{prob: prob_r, gidx: '0, gval: '0, last: 1'b0, lerr: lerr_r};
            out_tvalid <= 1'b1; st_r <= S_IDLE;
          end
        end
        S_READ: if (out_free) begin
          res_r <= '{prob: '0, gidx: i_r, gval: grad_r[i_r],
                     last: (i_r + 5'd1 == npar), lerr: 1'b0};
          out_tvalid <= 1'b1; i_r <= i_r + 5'd1;
          if (i_r + 5'd1 == npar) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ dv/tb_logistic_mixed_gradient_engine_unit.sv @@
`timescale 1ns / 100ps

module tb_logistic_mixed_gradient_engine_unit;
  import lmg_pkg::*;

  typedef struct {
    op_t              op;
    logic [4:0]       idx;
    logic [31:0]      val;
    logic [3:0][1:0]  cat;
    logic [3:0][31:0] cont;
    logic             label;
  } obs_item_t;

  typedef struct {
    logic [15:0] prob;
    logic [4:0]  gidx;
    logic [47:0] gval;
    logic        last;
    logic        lerr;
  } grad_beat_t;

  class grad_scoreboard;
    logic [2:0]  levels [NCAT];
    logic [2:0]  cont_cfg;
    logic [31:0] lam_l1;
    logic [31:0] lam_l2;
    longint      coef [NCOEF];
    longint      grad [NCOEF];
    grad_beat_t  pending_q [$];
    int          errors;

    function new();
      for (int k = 0; k < NCAT; k++) levels[k] = 3'd3;
      cont_cfg = '0;
      lam_l1 = '0;
      lam_l2 = '0;
      errors = 0;
      for (int i = 0; i < NCOEF; i++) begin
        coef[i] = 0;
        grad[i] = 0;
      end
    endfunction

    function void set_reg(reg_t r, logic [31:0] v);
      case (r)
        REG_CONT: cont_cfg = v[2:0];
        REG_L1:   lam_l1 = v;
        REG_L2:   lam_l2 = v;
        default:  levels[r] = v[2:0];
      endcase
    endfunction

    function int eff_lev(int k);
      if (levels[k] < 1) return 1;
      if (levels[k] > NLEV) return NLEV;
      return levels[k];
    endfunction

    function int eff_cont();
      return (cont_cfg > NCONT) ? NCONT : cont_cfg;
    endfunction

    function int num_params();
      int n;
      n = 1 + eff_cont();
      for (int k = 0; k < NCAT; k++) n += eff_lev(k) - 1;
      return n;
    endfunction

    function longint clip48(longint v);
      if (v > 64'sh00007FFFFFFFFFFF) return 64'sh00007FFFFFFFFFFF;
      if (v < -64'sh0000800000000000) return -64'sh0000800000000000;
      return v;
    endfunction

    function longint sigmoid(longint eta);
      longint a, y, p;
      a = (eta < 0) ? -eta : eta;
      if (a >= 5 * 64'sd16777216) y = 64'sd16777216;
      else if (a >= 64'sd39845888) y = (a >>> 5) + 64'sd14155776;
      else if (a >= 64'sd16777216) y = (a >>> 3) + 64'sd10485760;
      else y = (a >>> 2) + 64'sd8388608;
      p = (eta >= 0) ? y : 64'sd16777216 - y;
      p = (p + 128) >>> 8;
      return (p > 65535) ? 65535 : p;
    endfunction

    function void note_input(obs_item_t it);
      int npar, base, nc;
      int slot [NCAT];
      bit used [NCAT];
      bit lerr;
      longint eta, prob, err, t, xc;
      grad_beat_t b;
      npar = num_params();
      nc = eff_cont();
      case (it.op)
        OP_LOAD: if (it.idx < NCOEF) coef[it.idx] = longint'($signed(it.val));
        OP_START: begin
          for (int i = 0; i < NCOEF; i++) begin
            if (i == 0 || i >= npar) begin
              grad[i] = 0;
            end else begin
              t = (coef[i] * longint'({32'd0, lam_l2})) >>> 16;
              if (coef[i] > 0) t += longint'({32'd0, lam_l1}) * 256;
              else if (coef[i] < 0) t -= longint'({32'd0, lam_l1}) * 256;
              grad[i] = clip48(t);
            end
          end
        end
        OP_OBS: begin
          base = 1;
          lerr = 0;
          eta = coef[0];
          for (int k = 0; k < NCAT; k++) begin
            used[k] = 0;
            slot[k] = 0;
            if (it.cat[k] >= eff_lev(k)) begin
              lerr = 1;
            end else if (it.cat[k] > 0) begin
              used[k] = 1;
              slot[k] = base + it.cat[k] - 1;
              eta += coef[slot[k]];
            end
            base += eff_lev(k) - 1;
          end
          for (int k = 0; k < nc; k++)
            eta += (longint'($signed(it.cont[k])) * coef[base + k]) >>> 16;
          prob = sigmoid(eta);
          err = prob - (it.label ? 65536 : 0);
          grad[0] = clip48(grad[0] + err * 256);
          for (int k = 0; k < NCAT; k++)
            if (used[k]) grad[slot[k]] = clip48(grad[slot[k]] + err * 256);
          for (int k = 0; k < nc; k++) begin
            xc = longint'($signed(it.cont[k]));
            grad[base + k] = clip48(grad[base + k] + ((xc * err) >>> 8));
          end
          b.prob = prob[15:0];
          b.gidx = '0;
          b.gval = '0;
          b.last = 1'b0;
          b.lerr = lerr;
          pending_q.push_back(b);
        end
        OP_READ: begin
          for (int i = 0; i < npar; i++) begin
            b.prob = '0;
            b.gidx = i[4:0];
            b.gval = grad[i][47:0];
            b.last = (i + 1 == npar);
            b.lerr = 1'b0;
            pending_q.push_back(b);
          end
        end
      endcase
    endfunction

    function void check_result(grad_beat_t act);
      grad_beat_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result prob=%h gidx=%0d gval=%h last=%b lerr=%b",
                 $time, act.prob, act.gidx, act.gval, act.last, act.lerr);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (e.prob !== act.prob) begin
        $display("%0t: probability exp %h act %h", $time, e.prob, act.prob);
        errors++;
      end
      if (e.gidx !== act.gidx) begin
        $display("%0t: grad_index exp %0d act %0d", $time, e.gidx, act.gidx);
        errors++;
      end
      if (e.gval !== act.gval) begin
        $display("%0t: grad_value exp %h act %h", $time, e.gval, act.gval);
        errors++;
      end
      if (e.last !== act.last) begin
        $display("%0t: last exp %b act %b", $time, e.last, act.last);
        errors++;
      end
      if (e.lerr !== act.lerr) begin
        $display("%0t: level_error exp %b act %b", $time, e.lerr, act.lerr);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [175:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  grad_scoreboard sb;
  bit             no_idle;
  bit             hold_req;

  logistic_mixed_gradient_engine_unit uut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [175:0] pack_item(obs_item_t it);
    logic [175:0] d;
    d = '0;
    d[4:0] = it.idx;
    d[36:5] = it.val;
    for (int k = 0; k < NCAT; k++) d[37 + 2*k +: 2] = it.cat[k];
    for (int k = 0; k < NCONT; k++) d[45 + 32*k +: 32] = it.cont[k];
    d[173] = it.label;
    return d;
  endfunction

  function automatic logic [31:0] pick_word(bit narrow);
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return narrow ? $urandom_range(0, 32'h3_FFFF) - 32'h2_0000 : $urandom;
    endcase
  endfunction

  function automatic obs_item_t make_item(op_t op);
    obs_item_t it;
    it.op = op;
    it.idx = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                         : 5'($urandom_range(0, 16));
    it.val = pick_word(1);
    for (int k = 0; k < NCAT; k++) it.cat[k] = 2'($urandom_range(0, 3));
    for (int k = 0; k < NCONT; k++) it.cont[k] = pick_word(1);
    it.label = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send(obs_item_t it);
    int gap;
    gap = no_idle ? 0 : (($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0);
    if (gap > 0) begin
      in_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = pack_item(it);
    in_tuser = it.op;
    do @(posedge clk); while (!in_tready);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(reg_t r, logic [31:0] v);
    cfg_psel = 1;
    cfg_pwrite = 1;
    cfg_penable = 0;
    cfg_paddr = {r, 2'b00};
    cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(r, v);
    @(negedge clk);
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
  endtask

  task automatic configure(logic [2:0] l0, logic [2:0] l1, logic [2:0] l2, logic [2:0] l3,
                           logic [2:0] nc, logic [31:0] w1, logic [31:0] w2);
    cfg_write(REG_LEV0, 32'(l0));
    cfg_write(REG_LEV1, 32'(l1));
    cfg_write(REG_LEV2, 32'(l2));
    cfg_write(REG_LEV3, 32'(l3));
    cfg_write(REG_CONT, 32'(nc));
    cfg_write(REG_L1, w1);
    cfg_write(REG_L2, w2);
  endtask

  task automatic random_items(int n);
    int r;
    op_t op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r < 3) op = OP_LOAD;
      else if (r < 5) op = OP_START;
      else if (r < 8) op = OP_READ;
      else op = OP_OBS;
      send(make_item(op));
    end
  endtask

  always @(posedge clk) begin
    grad_beat_t b;
    if (rst_n && out_tvalid && out_tready) begin
      b.prob = out_tdata[15:0];
      b.gidx = out_tdata[20:16];
      b.gval = out_tdata[68:21];
      b.lerr = out_tdata[69];
      b.last = out_tlast;
      sb.check_result(b);
    end
  end

  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_tready = 0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        out_tready = 1;
      end
    end
  end

  initial begin
    int idle_cnt;
    idle_cnt = 0;
    while (idle_cnt < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt = 0;
      else idle_cnt++;
    end
    $display("** logistic_mixed_gradient_engine_unit: FAILED **");
    $finish;
  end

  initial begin
    obs_item_t it;
    sb = new();
    no_idle = 0;
    hold_req = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    configure(3'd4, 3'd3, 3'd2, 3'd1, 3'd4, 32'hFFFF_FFFF, 32'h0001_0000);
    for (int i = 0; i < NCOEF; i++) begin
      it = make_item(OP_LOAD);
      it.idx = 5'(i);
      it.val = (i == 1) ? 32'h8000_0000 : (i == 2) ? 32'h7FFF_FFFF : (i == 3) ? 32'h0 :
               $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      send(it);
    end
    it = make_item(OP_LOAD);
    it.idx = 5'd17;
    send(it);
    it.idx = 5'd31;
    send(it);
    send(make_item(OP_START));
    it = make_item(OP_OBS);
    it.cat = {2'd3, 2'd3, 2'd3, 2'd3};
    it.cont = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0};
    it.label = 1'b1;
    send(it);
    it.cat = {2'd0, 2'd1, 2'd2, 2'd3};
    it.cont = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000};
    it.label = 1'b0;
    send(it);
    it.cat = '0;
    it.cont = '0;
    send(it);
    send(make_item(OP_READ));
    drain();

    configure(3'd1, 3'd1, 3'd1, 3'd1, 3'd0, 32'h0, 32'h0);
    random_items(20);
    drain();

    configure(3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    hold_req = 1;
    random_items(25);
    drain();

    configure(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
              3'($urandom_range(0, 7)), 3'($urandom_range(5, 7)), $urandom, $urandom);
    random_items(25);
    drain();

    no_idle = 1;
    configure(3'($urandom_range(1, 4)), 3'($urandom_range(1, 4)), 3'($urandom_range(1, 4)),
              3'($urandom_range(1, 4)), 3'($urandom_range(0, 4)),
              $urandom_range(0, 32'h3_0000), $urandom_range(0, 32'h3_0000));
    random_items(26);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("** logistic_mixed_gradient_engine_unit: PASSED **");
    else
      $display("** logistic_mixed_gradient_engine_unit: FAILED **");
    $finish;
  end
endmodule
